>>> hdl/chained_hash_table_engine_defines.svh
// Assertion macros for the chained hash table engine.
// Used by files that check concurrent properties on clk and rst_n.
`ifndef CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH
`define CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication
`define CHTE_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chte assertion failed");

// next-cycle implication
`define CHTE_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chte assertion failed");

`endif

>>> hdl/chte_pkg.sv
// Package for the chained hash table engine: payload types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package chte_pkg;

  localparam int KEY_BYTES_DEF  = 8;
  localparam int VALUE_BITS_DEF = 32;
  localparam int BUCKETS_DEF    = 256;
  localparam int NODES_DEF      = 512;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  // FNV prime is 2^40 + 0x1b3
  localparam logic [8:0]  FNV_LOW   = 9'h1b3;

  localparam logic [1:0] K_INSERT = 2'd0;
  localparam logic [1:0] K_FIND   = 2'd1;
  localparam logic [1:0] K_DELETE = 2'd2;
  localparam logic [1:0] K_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [31:0] value;
  } chte_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [9:0]  entry_count;
  } chte_out_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [31:0] value;
    logic [15:0] bucket;
  } chte_work_t;

endpackage

>>> hdl/chte_front.sv
// Front end: accepts requests, masks the key and hashes it one byte per cycle.
// Depends on chte_pkg.
`timescale 1ns / 1ps
module chte_front import chte_pkg::*; #(
  parameter int KEY_BYTES = KEY_BYTES_DEF,
  parameter int BUCKETS   = BUCKETS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  chte_in_t   in_data,
  output logic       wq_valid,
  input  logic       wq_ready,
  output chte_work_t wq_data
);

  localparam int IW = $clog2(KEY_BYTES + 1);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [63:0] KMASK =
    (KEY_BYTES >= 8) ? '1 : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
  localparam logic [BW-1:0] BMASK = BW'(BUCKETS - 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_PUSH = 3'b100
  } fst_t;

  fst_t        st_r, st_nxt;
  logic [1:0]  kind_r;
  logic [63:0] key_r, ksh_r;
  logic [31:0] val_r;
  logic [63:0] h_r, hx;
  logic [IW-1:0] cnt_r;

  assign in_ready = (st_r == F_IDLE);
  assign wq_valid = (st_r == F_PUSH);
  assign hx       = h_r ^ {56'd0, ksh_r[7:0]};

  always_comb begin
    wq_data        = '0;
    wq_data.kind   = kind_r;
    wq_data.key    = key_r;
    wq_data.value  = val_r;
    wq_data.bucket = 16'(h_r[BW-1:0] & BMASK);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE: if (in_valid) st_nxt = F_HASH;
      F_HASH: if (cnt_r == IW'(KEY_BYTES - 1)) st_nxt = F_PUSH;
      F_PUSH: if (wq_ready) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && in_valid) begin
      kind_r <= in_data.kind;
      key_r  <= in_data.key & KMASK;
      ksh_r  <= in_data.key;
      val_r  <= in_data.value;
      h_r    <= FNV_BASIS;
      cnt_r  <= '0;
    end else if (st_r == F_HASH) begin
      h_r   <= (hx << 40) + 64'(hx * 64'(FNV_LOW));
      ksh_r <= ksh_r >> 8;
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

>>> hdl/chte_fifo.sv
// Two-entry queue of hashed requests between front and back end.
// Depends on chte_pkg.
`timescale 1ns / 1ps
module chte_fifo import chte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  chte_work_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output chte_work_t rd_data
);

  chte_work_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

>>> hdl/chte_back.sv
// Back end: bucket heads, node pool and free stack; walks chains and answers.
// Depends on chte_pkg.
`timescale 1ns / 1ps
module chte_back import chte_pkg::*; #(
  parameter int KEY_BYTES  = KEY_BYTES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int NODES      = NODES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rq_valid,
  output logic       rq_ready,
  input  chte_work_t rq_data,
  output logic       out_valid,
  input  logic       out_ready,
  output chte_out_t  out_data
);

  localparam int KW = 8 * KEY_BYTES;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int LW = NW + 1;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_HEAD = 5'b00010,
    B_RD   = 5'b00100,
    B_CMP  = 5'b01000,
    B_DONE = 5'b10000
  } bst_t;

  logic [NW-1:0]         bh_mem [BUCKETS];
  logic [KW-1:0]         nk_mem [NODES];
  logic [VALUE_BITS-1:0] nv_mem [NODES];
  logic [LW-1:0]         nl_mem [NODES];
  logic [NW-1:0]         fs_mem [NODES];

  bst_t st_r, st_nxt;
  logic [1:0]   kind_r;
  logic [KW-1:0] key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [BW-1:0] bkt_r;
  logic [NW-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic          hp_r, hp_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [CW-1:0] ftop_r, ftop_nxt, low_r, low_nxt, cnt_r, cnt_nxt;
  logic [BUCKETS-1:0] bhv_r, bhv_nxt;
  chte_out_t res_r, res_nxt, out_r;
  logic          out_valid_r;

  logic [NW-1:0] bh_q, fs_q;
  logic [KW-1:0] nk_q;
  logic [VALUE_BITS-1:0] nv_q;
  logic [LW-1:0] nl_q;
  logic          fresh_q;

  logic [CW-1:0] fpos;
  logic [NW-1:0] fnode;
  logic [BW-1:0] bh_raddr;
  logic          miss, hit;
  logic [63:0]   vext;

  logic          bh_we, nk_we, nv_we, nl_we, fs_we;
  logic [NW-1:0] bh_wd, nkv_addr, nl_addr;
  logic [LW-1:0] nl_wd;

  assign rq_ready  = (st_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign fpos      = ftop_r - 1'b1;
  assign fnode     = fresh_q ? (NW'(NODES - 1) - fpos[NW-1:0]) : fs_q;
  assign bh_raddr  = (st_r == B_IDLE) ? rq_data.bucket[BW-1:0] : bkt_r;
  assign hit       = (st_r == B_CMP) && (nk_q == key_r);
  assign vext      = 64'(nv_q);

  always_comb begin
    st_nxt    = st_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    hp_nxt    = hp_r;
    steps_nxt = steps_r;
    ftop_nxt  = ftop_r;
    low_nxt   = low_r;
    cnt_nxt   = cnt_r;
    bhv_nxt   = bhv_r;
    res_nxt   = res_r;
    bh_we = 1'b0; nk_we = 1'b0; nv_we = 1'b0; nl_we = 1'b0; fs_we = 1'b0;
    bh_wd = fnode; nkv_addr = fnode; nl_addr = fnode;
    nl_wd = {bhv_r[bkt_r], bh_q};
    miss  = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (rq_valid) begin
          if (rq_data.kind == K_CLEAR) begin
            bhv_nxt  = '0;
            ftop_nxt = CW'(NODES);
            low_nxt  = CW'(NODES);
            cnt_nxt  = '0;
            res_nxt  = '{status: ST_OK, value_out: 32'd0, entry_count: 10'd0};
            st_nxt   = B_DONE;
          end else begin
            st_nxt = B_HEAD;
          end
        end
      end
      B_HEAD: begin
        cur_nxt   = bh_q;
        hp_nxt    = 1'b0;
        steps_nxt = '0;
        if (bhv_r[bkt_r]) st_nxt = B_RD;
        else miss = 1'b1;
      end
      B_RD: st_nxt = B_CMP;
      B_CMP: begin
        if (hit) begin
          res_nxt = '{status: ST_OK, value_out: 32'd0, entry_count: 10'(cnt_r)};
          st_nxt  = B_DONE;
          case (kind_r)
            K_INSERT: begin
              nv_we    = 1'b1;
              nkv_addr = cur_r;
            end
            K_FIND: res_nxt.value_out = vext[31:0];
            default: begin
              if (hp_r) begin
                nl_we   = 1'b1;
                nl_addr = prev_r;
                nl_wd   = nl_q;
              end else begin
                bh_we = 1'b1;
                bh_wd = nl_q[NW-1:0];
                bhv_nxt[bkt_r] = nl_q[NW];
              end
              if (ftop_r < CW'(NODES)) begin
                fs_we    = 1'b1;
                ftop_nxt = ftop_r + 1'b1;
              end
              if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
              res_nxt.entry_count = 10'(cnt_nxt);
            end
          endcase
        end else begin
          steps_nxt = steps_r + 1'b1;
          prev_nxt  = cur_r;
          hp_nxt    = 1'b1;
          cur_nxt   = nl_q[NW-1:0];
          if (!nl_q[NW] || steps_nxt == CW'(NODES) ||
              32'(nl_q[NW-1:0]) >= 32'(NODES)) miss = 1'b1;
          else st_nxt = B_RD;
        end
      end
      B_DONE: if (!out_valid_r || out_ready) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
    if (miss) begin
      st_nxt  = B_DONE;
      res_nxt = '{status: ST_NOTFOUND, value_out: 32'd0, entry_count: 10'(cnt_r)};
      if (kind_r == K_INSERT) begin
        if (ftop_r == '0) begin
          res_nxt.status = ST_FULL;
        end else begin
          res_nxt.status = ST_OK;
          nk_we = 1'b1; nv_we = 1'b1; nl_we = 1'b1; bh_we = 1'b1;
          bhv_nxt[bkt_r] = 1'b1;
          ftop_nxt = fpos;
          if (fpos < low_r) low_nxt = fpos;
          cnt_nxt  = cnt_r + 1'b1;
          res_nxt.entry_count = 10'(cnt_nxt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      ftop_r      <= CW'(NODES);
      low_r       <= CW'(NODES);
      cnt_r       <= '0;
      bhv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ftop_r <= ftop_nxt;
      low_r  <= low_nxt;
      cnt_r  <= cnt_nxt;
      bhv_r  <= bhv_nxt;
      if (st_r == B_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    hp_r    <= hp_nxt;
    steps_r <= steps_nxt;
    res_r   <= res_nxt;
    if (st_r == B_DONE && (!out_valid_r || out_ready)) out_r <= res_r;
    if (st_r == B_IDLE && rq_valid) begin
      kind_r <= rq_data.kind;
      key_r  <= rq_data.key[KW-1:0];
      val_r  <= VALUE_BITS'(64'(rq_data.value));
      bkt_r  <= rq_data.bucket[BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    bh_q    <= bh_mem[bh_raddr];
    fs_q    <= fs_mem[fpos[NW-1:0]];
    fresh_q <= (fpos < low_r);
    nk_q    <= nk_mem[cur_r];
    nv_q    <= nv_mem[cur_r];
    nl_q    <= nl_mem[cur_r];
    if (bh_we) bh_mem[bkt_r] <= bh_wd;
    if (nk_we) nk_mem[nkv_addr] <= key_r;
    if (nv_we) nv_mem[nkv_addr] <= val_r;
    if (nl_we) nl_mem[nl_addr] <= nl_wd;
    if (fs_we) fs_mem[ftop_r[NW-1:0]] <= cur_r;
  end

endmodule

>>> hdl/chained_hash_table_engine.sv
// Chained hash table engine, top level: front hasher, request queue, back end.
// Depends on chte_pkg, chte_front, chte_fifo, chte_back and the defines header.
`timescale 1ns / 1ps
`include "chained_hash_table_engine_defines.svh"
// One request in, one result out. The front hashes the key with 64-bit FNV-1a,
// one byte per cycle, and queues the request; the back end then reads the
// bucket head, visits each chain node in states B_RD and B_CMP through the
// node memories' registered read port, and posts the result from B_DONE; a
// clear goes straight to B_DONE. The front hashes the next request while the
// back walks. The result register holds a finished answer while the next
// request proceeds. No clearing pass: reset and clear take effect at once.
module chained_hash_table_engine import chte_pkg::*; #(
  parameter int KEY_BYTES  = KEY_BYTES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int NODES      = NODES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  chte_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output chte_out_t out_data
);

  logic       wq_valid, wq_ready, rq_valid, rq_ready;
  chte_work_t wq_data, rq_data;

  chte_front #(.KEY_BYTES(KEY_BYTES), .BUCKETS(BUCKETS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .wq_valid(wq_valid), .wq_ready(wq_ready), .wq_data(wq_data)
  );

  chte_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(wq_valid), .wr_ready(wq_ready), .wr_data(wq_data),
    .rd_valid(rq_valid), .rd_ready(rq_ready), .rd_data(rq_data)
  );

  chte_back #(
    .KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS),
    .BUCKETS(BUCKETS), .NODES(NODES)
  ) u_back (
    .clk, .rst_n,
    .rq_valid(rq_valid), .rq_ready(rq_ready), .rq_data(rq_data),
    .out_valid, .out_ready, .out_data
  );

  `CHTE_AST_NEXT(a_front_busy, in_valid && in_ready, !in_ready)
  `CHTE_AST_NOW(a_full_count, out_valid && out_data.status == ST_FULL, out_data.entry_count == 10'(NODES))
  `CHTE_AST_NOW(a_miss_novalue, out_valid && out_data.status != ST_OK, out_data.value_out == 32'd0)

endmodule
